### hdl/block_spin_renormalizer_top_defines.svh
// ----------------------------------------------------------------------------
// Block spin renormalizer - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SPIN_RENORMALIZER_TOP_DEFINES_SVH
`define BLOCK_SPIN_RENORMALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define BRN_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRN_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/brn_pkg.sv
// ----------------------------------------------------------------------------
// Block spin renormalizer - package
// Word types, opcodes, register indexes and field widths.
// ----------------------------------------------------------------------------
package brn_pkg;

    localparam int COORD_W = 6;
    localparam int COUNT_W = 7;
    localparam int UPS_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic MODE_MAJORITY = 1'b0;
    localparam logic MODE_DECIMATE = 1'b1;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [1:0] REG_COL_COUNT = 2'd2;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               spin_up;
    } t_cmd;

    typedef struct packed {
        logic             block_spin_up;
        logic [UPS_W-1:0] ups_in_block;
    } t_res;

endpackage

### hdl/brn_divmod.sv
// ----------------------------------------------------------------------------
// Block spin renormalizer - remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module brn_divmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brn_pkg::COUNT_W-1:0] i_dividend,
    input  logic [brn_pkg::COUNT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [brn_pkg::COUNT_W-1:0] o_rem
);

    localparam int W  = brn_pkg::COUNT_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_rem,  n_rem;
    logic [W-1:0]  r_dvd,  n_dvd;
    logic [W-1:0]  r_div,  n_div;
    logic [W:0]    trial;

    assign trial = {r_rem, r_dvd[W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = W'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[W-1:0];
            end
            n_dvd = {r_dvd[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hdl/brn_lattice.sv
// ----------------------------------------------------------------------------
// Block spin renormalizer - lattice memory
// One-bit spin store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module brn_lattice #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [(1 << AW)];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/block_spin_renormalizer_top.sv
// Write word: accepted every cycle while busy is low, no result, busy stays low.
// Read word: busy stays high until the result strobe, so a read is taken only after the last ends;
//   its duration is set by the 7-step remainder units and four reads of the single lattice port.
// Results cannot be stalled; the strobe lasts one cycle.
// Reset: synchronous, active low; mode 0 and both counts 64, lattice undefined.
// ----------------------------------------------------------------------------
// Block spin renormalizer - top level
// 2x2 majority or decimation over a periodic one-bit spin lattice.
// ----------------------------------------------------------------------------
module block_spin_renormalizer_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  brn_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    output brn_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;
    localparam int NW = brn_pkg::COUNT_W;
    localparam int UW = brn_pkg::UPS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ORG  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;

    logic          r_mode;
    logic [NW-1:0] r_row_count;
    logic [NW-1:0] r_col_count;
    logic          cfg_wr;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_idx,   n_idx;
    logic [NW-1:0] r_nr,    n_nr;
    logic [NW-1:0] r_nc,    n_nc;
    logic [RW-1:0] r_r0, r_r1, n_r0, n_r1;
    logic [CW-1:0] r_c0, r_c1, n_c0, n_c1;
    logic [UW-1:0] r_ups,   n_ups;
    logic          r_tl,    n_tl;
    logic          r_pend,  r_pend_first;
    logic          r_res_valid, n_res_valid;
    brn_pkg::t_res r_res,   n_res;

    logic          accept, acc_read, acc_write;
    logic [NW-1:0] nr_clamp, nc_clamp;
    logic          row_done;
    logic          col_done;
    logic [NW-1:0] row_rem, col_rem;
    logic [NW-1:0] row_o0, row_o1, col_o0, col_o1;

    logic          mem_we, mem_re, mem_rdata;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [UW-1:0] ups_sum;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= brn_pkg::MODE_MAJORITY;
            r_row_count <= brn_pkg::COUNT_RESET;
            r_col_count <= brn_pkg::COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                brn_pkg::REG_MODE:      r_mode      <= pwdata[0];
                brn_pkg::REG_ROW_COUNT: r_row_count <= pwdata[NW-1:0];
                brn_pkg::REG_COL_COUNT: r_col_count <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            brn_pkg::REG_MODE:      prdata = {31'd0, r_mode};
            brn_pkg::REG_ROW_COUNT: prdata = {{(32-NW){1'b0}}, r_row_count};
            brn_pkg::REG_COL_COUNT: prdata = {{(32-NW){1'b0}}, r_col_count};
            default:                prdata = '0;
        endcase
    end

    // saturate counts to 1..MAX
    always_comb begin
        if (r_row_count == '0) begin
            nr_clamp = NW'(1);
        end else if (int'(r_row_count) > MAX_ROWS) begin
            nr_clamp = NW'(MAX_ROWS);
        end else begin
            nr_clamp = r_row_count;
        end
        if (r_col_count == '0) begin
            nc_clamp = NW'(1);
        end else if (int'(r_col_count) > MAX_COLS) begin
            nc_clamp = NW'(MAX_COLS);
        end else begin
            nc_clamp = r_col_count;
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign accept    = start & ~busy;
    assign acc_read  = accept & (i_cmd.op == brn_pkg::OP_READ);
    assign acc_write = accept & (i_cmd.op == brn_pkg::OP_WRITE);

    // (2k) mod n for rows and columns
    brn_divmod u_row_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc_read),
        .i_dividend ({i_cmd.row, 1'b0}),
        .i_divisor  (nr_clamp),
        .o_done     (row_done),
        .o_rem      (row_rem)
    );

    brn_divmod u_col_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc_read),
        .i_dividend ({i_cmd.col, 1'b0}),
        .i_divisor  (nc_clamp),
        .o_done     (col_done),
        .o_rem      (col_rem)
    );

    // block origin and its wrapped neighbor
    always_comb begin
        logic [NW:0] t_row, t_col, i_row, i_col;
        t_row = {1'b0, row_rem} + {1'b0, r_nr - (r_nr >> 1)};
        t_col = {1'b0, col_rem} + {1'b0, r_nc - (r_nc >> 1)};
        row_o0 = (t_row >= {1'b0, r_nr}) ? NW'(t_row - {1'b0, r_nr}) : t_row[NW-1:0];
        col_o0 = (t_col >= {1'b0, r_nc}) ? NW'(t_col - {1'b0, r_nc}) : t_col[NW-1:0];
        i_row = {1'b0, row_o0} + 1'b1;
        i_col = {1'b0, col_o0} + 1'b1;
        row_o1 = (i_row == {1'b0, r_nr}) ? '0 : i_row[NW-1:0];
        col_o1 = (i_col == {1'b0, r_nc}) ? '0 : i_col[NW-1:0];
    end

    // lattice access
    assign mem_we    = acc_write & (int'(i_cmd.row) < MAX_ROWS) & (int'(i_cmd.col) < MAX_COLS);
    assign mem_waddr = {RW'(i_cmd.row), CW'(i_cmd.col)};
    assign mem_re    = (r_state == S_READ) & ~r_idx[2];

    always_comb begin
        unique case (r_idx[1:0])
            2'd0:    mem_raddr = {r_r0, r_c0};
            2'd1:    mem_raddr = {r_r1, r_c0};
            2'd2:    mem_raddr = {r_r0, r_c1};
            default: mem_raddr = {r_r1, r_c1};
        endcase
    end

    brn_lattice #(
        .AW (AW)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_cmd.spin_up),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign ups_sum = r_pend_first ? UW'(mem_rdata) : r_ups + UW'(mem_rdata);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_nr        = r_nr;
        n_nc        = r_nc;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_ups       = r_ups;
        n_tl        = r_tl;
        n_res_valid = 1'b0;
        n_res       = r_res;
        if (r_pend) begin
            n_ups = ups_sum;
            if (r_pend_first) begin
                n_tl = mem_rdata;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc_read) begin
                    n_nr    = nr_clamp;
                    n_nc    = nc_clamp;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (row_done && col_done) begin
                    n_state = S_ORG;
                end
            end
            S_ORG: begin
                n_r0    = RW'(row_o0);
                n_r1    = RW'(row_o1);
                n_c0    = CW'(col_o0);
                n_c1    = CW'(col_o1);
                n_idx   = '0;
                n_state = S_READ;
            end
            S_READ: begin
                n_idx = r_idx + 1'b1;
                if (r_idx[2]) begin
                    n_state                = S_IDLE;
                    n_res_valid            = 1'b1;
                    n_res.ups_in_block     = ups_sum;
                    if (r_mode == brn_pkg::MODE_DECIMATE || ups_sum == UW'(2)) begin
                        n_res.block_spin_up = r_tl;
                    end else begin
                        n_res.block_spin_up = (ups_sum > UW'(2));
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_pend_first <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend       <= mem_re;
            r_pend_first <= mem_re & (r_idx[1:0] == 2'd0);
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nr  <= n_nr;
        r_nc  <= n_nc;
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_c0  <= n_c0;
        r_c1  <= n_c1;
        r_ups <= n_ups;
        r_tl  <= n_tl;
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### hdl/brn_checker.sv
// ----------------------------------------------------------------------------
// Block spin renormalizer - port checker
// Port-level properties of the command and result sides, bound to the top.
// ----------------------------------------------------------------------------
`include "block_spin_renormalizer_top_defines.svh"

module brn_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input brn_pkg::t_cmd i_cmd,
    input logic          o_res_valid,
    input brn_pkg::t_res o_res
);

    logic acc_read;
    logic acc_write;

    assign acc_read  = start && !busy && i_cmd.op == brn_pkg::OP_READ;
    assign acc_write = start && !busy && i_cmd.op == brn_pkg::OP_WRITE;

    `BRN_CHK_NEXT(a_read_busy, acc_read, busy, "read word did not raise busy")
    `BRN_CHK_NEXT(a_write_quiet, acc_write, !busy && !o_res_valid, "write word caused activity")
    `BRN_CHK_NOW(a_res_idle, o_res_valid, !busy, "result shown while busy")
    `BRN_CHK_NEXT(a_res_single, o_res_valid, !o_res_valid, "result strobe repeated")
    `BRN_CHK_NOW(a_ups_range, o_res_valid, o_res.ups_in_block <= 3'd4, "up count out of range")

endmodule

bind block_spin_renormalizer_top brn_checker u_brn_checker (.*);

### sim/block_spin_renormalizer_top_test.sv
// ----------------------------------------------------------------------------
// Block spin renormalizer - testbench
// Writes every block before it is first read, runs directed corner cases and
// then random command words over many register settings. A scoreboard keeps
// its own lattice and registers, predicts the renormalized spin of every read
// word and checks each result word in order.
// ----------------------------------------------------------------------------
module block_spin_renormalizer_top_test;

    localparam int ROWS          = 64;
    localparam int COLS          = 64;
    localparam int XW            = brn_pkg::COORD_W;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SEGMENTS      = 9;
    localparam int SEGMENT_WORDS = 205;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    class renorm_tracker;
        bit                          lattice [ROWS*COLS];
        bit                          written [ROWS*COLS];
        logic                        mode;
        logic [brn_pkg::COUNT_W-1:0] row_count;
        logic [brn_pkg::COUNT_W-1:0] col_count;
        brn_pkg::t_res               pending_blocks [$];
        int                          mismatches;

        function new();
            mode       = brn_pkg::MODE_MAJORITY;
            row_count  = brn_pkg::COUNT_RESET;
            col_count  = brn_pkg::COUNT_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                brn_pkg::REG_MODE:      mode = value[0];
                brn_pkg::REG_ROW_COUNT: row_count = value[brn_pkg::COUNT_W-1:0];
                brn_pkg::REG_COL_COUNT: col_count = value[brn_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                brn_pkg::REG_MODE:      return {31'b0, mode};
                brn_pkg::REG_ROW_COUNT: return {{(32-brn_pkg::COUNT_W){1'b0}}, row_count};
                brn_pkg::REG_COL_COUNT: return {{(32-brn_pkg::COUNT_W){1'b0}}, col_count};
                default:                return 32'b0;
            endcase
        endfunction

        function int unsigned count_in_use(logic [brn_pkg::COUNT_W-1:0] cnt,
                                           int unsigned limit);
            if (cnt == 0) return 1;
            if (int'(cnt) > limit) return limit;
            return cnt;
        endfunction

        function int unsigned block_start(int unsigned k, int unsigned n);
            return ((2 * k) % n + n - n / 2) % n;
        endfunction

        // corner 0 top-left, 1 next row, 2 next column, 3 both
        function int unsigned block_site(brn_pkg::t_cmd c, int unsigned k);
            int unsigned nr;
            int unsigned nc;
            int unsigned r;
            int unsigned col;
            nr  = count_in_use(row_count, ROWS);
            nc  = count_in_use(col_count, COLS);
            r   = block_start(int'(c.row), nr);
            col = block_start(int'(c.col), nc);
            if (k[0]) r = (r + 1) % nr;
            if (k[1]) col = (col + 1) % nc;
            return r * COLS + col;
        endfunction

        function int block_gap(brn_pkg::t_cmd c);
            for (int k = 0; k < 4; k++)
                if (!written[block_site(c, k)]) return int'(block_site(c, k));
            return -1;
        endfunction

        function brn_pkg::t_res renormalize(brn_pkg::t_cmd c);
            int unsigned   ups;
            bit            top_left;
            brn_pkg::t_res r;
            top_left = lattice[block_site(c, 0)];
            ups = int'(top_left) + int'(lattice[block_site(c, 1)])
                + int'(lattice[block_site(c, 2)]) + int'(lattice[block_site(c, 3)]);
            r.ups_in_block = ups[brn_pkg::UPS_W-1:0];
            if (mode == brn_pkg::MODE_DECIMATE) r.block_spin_up = top_left;
            else if (ups > 2) r.block_spin_up = 1'b1;
            else if (ups < 2) r.block_spin_up = 1'b0;
            else r.block_spin_up = top_left;
            return r;
        endfunction

        function void note_word(brn_pkg::t_cmd c);
            if (c.op == brn_pkg::OP_WRITE) begin
                lattice[int'(c.row) * COLS + int'(c.col)] = c.spin_up;
                written[int'(c.row) * COLS + int'(c.col)] = 1'b1;
            end else begin
                pending_blocks.push_back(renormalize(c));
            end
        endfunction

        function void check_word(brn_pkg::t_res got);
            brn_pkg::t_res want;
            if (pending_blocks.size() == 0) begin
                $error("result word with none expected: block_spin_up %0b ups_in_block %0d",
                       got.block_spin_up, got.ups_in_block);
                mismatches++;
                return;
            end
            want = pending_blocks.pop_front();
            if (got.block_spin_up !== want.block_spin_up) begin
                $error("block_spin_up expected %0b actual %0b",
                       want.block_spin_up, got.block_spin_up);
                mismatches++;
            end
            if (got.ups_in_block !== want.ups_in_block) begin
                $error("ups_in_block expected %0d actual %0d",
                       want.ups_in_block, got.ups_in_block);
                mismatches++;
            end
        endfunction
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    brn_pkg::t_cmd i_cmd   = '0;
    logic          o_res_valid;
    brn_pkg::t_res o_res;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    renorm_tracker trk;
    int            idle_pct = 0;
    int            quiet    = 0;

    block_spin_renormalizer_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) trk.note_word(i_cmd);
            if (o_res_valid) trk.check_word(o_res);
            if ((start && !busy) || o_res_valid || (psel && penable && pready)) quiet = 0;
            else quiet = quiet + 1;
        end
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("block_spin_renormalizer_top_test failed");
        $finish;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        trk.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input logic [1:0] idx);
        logic [31:0] want;
        want = trk.reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata expected %0h actual %0h", want, prdata);
            trk.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic op, input logic [XW-1:0] row,
                             input logic [XW-1:0] col, input logic spin);
        brn_pkg::t_cmd c;
        int            gap;
        c.op      = op;
        c.row     = row;
        c.col     = col;
        c.spin_up = spin;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(15, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_site_write(input int unsigned site);
        send_word(brn_pkg::OP_WRITE, XW'(site / COLS), XW'(site % COLS),
                  1'($urandom_range(1)));
    endtask

    // write any unwritten site of the block, then read it
    task automatic send_read(input logic [XW-1:0] row, input logic [XW-1:0] col,
                             input logic spin);
        brn_pkg::t_cmd c;
        int unsigned   site;
        c         = '0;
        c.op      = brn_pkg::OP_READ;
        c.row     = row;
        c.col     = col;
        for (int k = 0; k < 4; k++) begin
            site = trk.block_site(c, k);
            if (!trk.written[site]) send_site_write(site);
        end
        send_word(brn_pkg::OP_READ, row, col, spin);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (trk.pending_blocks.size() != 0 || busy);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return 32'd64;
            4:       return 32'd127;
            default: return {25'($urandom_range(32'h1FF_FFFF)), 7'($urandom_range(127))};
        endcase
    endfunction

    initial begin
        brn_pkg::t_cmd   c;
        int              gap_site;
        logic [XW-1:0]   row;
        logic [XW-1:0]   col;
        logic            spin;

        trk = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_read(brn_pkg::REG_MODE);
        reg_read(brn_pkg::REG_ROW_COUNT);
        reg_read(brn_pkg::REG_COL_COUNT);

        // ties and a full block at the lattice origin
        send_word(brn_pkg::OP_WRITE, XW'(0), XW'(0), 1'b1);
        send_word(brn_pkg::OP_WRITE, XW'(0), XW'(1), 1'b1);
        send_word(brn_pkg::OP_WRITE, XW'(1), XW'(0), 1'b0);
        send_word(brn_pkg::OP_WRITE, XW'(1), XW'(1), 1'b0);
        send_read(XW'(16), XW'(16), 1'b0);
        send_word(brn_pkg::OP_WRITE, XW'(0), XW'(0), 1'b0);
        send_word(brn_pkg::OP_WRITE, XW'(1), XW'(1), 1'b1);
        send_read(XW'(16), XW'(16), 1'b1);
        send_word(brn_pkg::OP_WRITE, XW'(0), XW'(0), 1'b1);
        send_word(brn_pkg::OP_WRITE, XW'(1), XW'(0), 1'b1);
        send_read(XW'(16), XW'(16), 1'b0);
        send_read(XW'(0), XW'(0), 1'b1);
        send_read(XW'(63), XW'(63), 1'b1);
        send_read(XW'(0), XW'(63), 1'b0);
        send_read(XW'(63), XW'(0), 1'b1);
        settle();
        reg_write(brn_pkg::REG_MODE, {31'h7FFF_FFFF, brn_pkg::MODE_DECIMATE});
        send_read(XW'(16), XW'(16), 1'b0);
        send_read(XW'(63), XW'(63), 1'b1);
        settle();
        reg_write(brn_pkg::REG_ROW_COUNT, 32'd1);
        reg_write(brn_pkg::REG_COL_COUNT, 32'd0);
        reg_write(brn_pkg::REG_MODE, {31'b0, brn_pkg::MODE_MAJORITY});
        send_read(XW'(5), XW'(9), 1'b0);
        settle();
        reg_write(brn_pkg::REG_ROW_COUNT, 32'hFFFF_FFFF);
        reg_write(brn_pkg::REG_COL_COUNT, 32'd3);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        reg_read(brn_pkg::REG_ROW_COUNT);
        reg_read(brn_pkg::REG_COL_COUNT);
        send_read(XW'(63), XW'(1), 1'b1);
        send_read(XW'(2), XW'(62), 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            case (seg / 3)
                0:       idle_pct = 14;
                1:       idle_pct = 65;
                default: idle_pct = 0;
            endcase
            reg_write(brn_pkg::REG_MODE, $urandom);
            reg_write(brn_pkg::REG_ROW_COUNT, pick_count());
            reg_write(brn_pkg::REG_COL_COUNT, pick_count());
            reg_read(brn_pkg::REG_MODE);
            for (int n = 0; n < SEGMENT_WORDS; n++) begin
                row  = XW'($urandom_range(63));
                col  = XW'($urandom_range(63));
                spin = 1'($urandom_range(1));
                if ($urandom_range(99) < 55) begin
                    c         = '0;
                    c.op      = brn_pkg::OP_READ;
                    c.row     = row;
                    c.col     = col;
                    gap_site  = trk.block_gap(c);
                    // fill an unwritten site of the block instead of reading it
                    if (gap_site >= 0) send_site_write(gap_site);
                    else send_word(brn_pkg::OP_READ, row, col, spin);
                end else begin
                    send_word(brn_pkg::OP_WRITE, row, col, spin);
                end
            end
        end

        settle();
        if (trk.mismatches == 0 && trk.pending_blocks.size() == 0) begin
            $display("block_spin_renormalizer_top_test passed");
        end else begin
            $display("block_spin_renormalizer_top_test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/brn_pkg.sv
hdl/brn_divmod.sv
hdl/brn_lattice.sv
hdl/block_spin_renormalizer_top.sv
hdl/brn_checker.sv
sim/block_spin_renormalizer_top_test.sv
